// ===== hdl/dda_line_rasterizer_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef DDA_LINE_RASTERIZER_MACROS_SVH
`define DDA_LINE_RASTERIZER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DDA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DDA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/dda_pkg.sv =====
package dda_pkg;

   localparam int CoordW = 6;
   localparam int InW    = 8;
   localparam int ColorW = 8;
   localparam int AccW   = 14;
   localparam int CntW   = 6;

   localparam logic [CoordW-1:0] MaxCanvas   = 6'd63;
   localparam logic [CoordW-1:0] CanvasReset = 6'd63;

   typedef enum logic {
      CsrCanvasWidth  = 1'b0,
      CsrCanvasHeight = 1'b1
   } csr_index_type;

   typedef enum logic {
      DivXByY = 1'b0,
      DivYByX = 1'b1
   } div_sel_type;

   typedef struct packed {
      logic signed [InW-1:0] start_x;
      logic signed [InW-1:0] start_y;
      logic signed [InW-1:0] end_x;
      logic signed [InW-1:0] end_y;
      logic [ColorW-1:0]     pen_color;
   } dda_req_type;

   typedef struct packed {
      logic [CoordW-1:0] pixel_x;
      logic [CoordW-1:0] pixel_y;
      logic [ColorW-1:0] pixel_color;
      logic              last_pixel;
   } dda_rsp_type;

   typedef struct packed {
      logic        load;
      logic        setup;
      logic        prep;
      logic        div_go;
      div_sel_type div_sel;
      logic        step;
   } dda_cmd_type;

   typedef struct packed {
      logic both_nz;
      logic div_done;
      logic last;
   } dda_sts_type;

endpackage

// ===== hdl/dda_div.sv =====
module dda_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      go,
   input  logic [dda_pkg::CoordW-1:0] dividend,
   input  logic [dda_pkg::CoordW-1:0] divisor,
   output logic                      done,
   output logic [dda_pkg::CoordW-1:0] quotient,
   output logic [dda_pkg::CoordW-1:0] remainder
);

   localparam int W    = dda_pkg::CoordW;
   localparam int StepW = $clog2(W + 1);

   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     dvs_ff;
   logic [StepW-1:0] cnt_ff;
   logic             done_ff;
   logic [W:0]       shifted;
   logic [W+1:0]     diff;

   // one restoring step: bring in the next dividend bit, try the subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = {1'b0, shifted} - {2'b00, dvs_ff};
      if (!diff[W+1]) begin
         rem_in = diff[W-1:0];
         quo_in = {quo_ff[W-2:0], 1'b1};
      end else begin
         rem_in = shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            cnt_ff <= StepW'(W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - StepW'(1);
            if (cnt_ff == StepW'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (cnt_ff != '0) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== hdl/dda_dp.sv =====
module dda_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [dda_pkg::CoordW-1:0] canvas_width,
   input  logic [dda_pkg::CoordW-1:0] canvas_height,
   input  dda_pkg::dda_req_type       req,
   input  dda_pkg::dda_cmd_type       cmd,
   output dda_pkg::dda_sts_type       sts,
   output logic                       rsp_valid,
   output dda_pkg::dda_rsp_type       rsp_data
);

   localparam int W  = dda_pkg::CoordW;
   localparam int IW = dda_pkg::InW;
   localparam int AW = dda_pkg::AccW;
   localparam int CW = dda_pkg::CntW;

   localparam logic signed [AW-1:0] AccOne   = AW'(1);
   localparam logic signed [IW-1:0] CoordInc = IW'(1);
   localparam logic signed [IW-1:0] CoordDec = '1;

   function automatic logic [W-1:0] clamp_coord(input logic signed [IW-1:0] v,
                                                input logic [W-1:0] hi);
      logic signed [IW-1:0] hi_s;
      hi_s = $signed({{(IW-W){1'b0}}, hi});
      if (v < 0) begin
         return '0;
      end else if (v > hi_s) begin
         return hi;
      end else begin
         return v[W-1:0];
      end
   endfunction

   dda_pkg::dda_req_type req_ff;
   dda_pkg::dda_rsp_type rsp_data_ff;
   dda_pkg::div_sel_type sel_ff;

   logic [W-1:0]         ax_ff, ay_ff, bx_ff, by_ff;
   logic [W-1:0]         dx_ff, dy_ff;
   logic                 xneg_ff, yneg_ff;
   logic signed [IW-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [AW-1:0] qx_ff, qy_ff, rx_ff, ry_ff;
   logic signed [AW-1:0] qx_in, qy_in, rx_in, ry_in;
   logic signed [AW-1:0] qx_a, qy_a, rx_a, ry_a, dx_ext, dy_ext;
   logic [W-1:0]         quo_xy_ff, rem_xy_ff, quo_yx_ff, rem_yx_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 first_ff;
   logic                 rsp_valid_ff;

   logic [W-1:0]         w_eff, h_eff;
   logic                 swap;
   logic signed [IW-1:0] sx, sy, ex, ey;
   logic                 xneg_c, yneg_c;
   logic [W-1:0]         dx_c, dy_c;
   logic                 step_x, step_y, ends, last_c;
   logic [W-1:0]         div_dividend, div_divisor, div_quo, div_rem;
   logic                 div_done;

   assign w_eff = (canvas_width  > dda_pkg::MaxCanvas) ? dda_pkg::MaxCanvas : canvas_width;
   assign h_eff = (canvas_height > dda_pkg::MaxCanvas) ? dda_pkg::MaxCanvas : canvas_height;

   // order endpoints, both axes together
   always_comb begin
      swap = (req_ff.start_x > req_ff.end_x) || (req_ff.start_y > req_ff.end_y);
      sx   = swap ? req_ff.end_x   : req_ff.start_x;
      sy   = swap ? req_ff.end_y   : req_ff.start_y;
      ex   = swap ? req_ff.start_x : req_ff.end_x;
      ey   = swap ? req_ff.start_y : req_ff.end_y;
   end

   // deltas and directions from the clamped endpoints
   always_comb begin
      xneg_c = ax_ff > bx_ff;
      yneg_c = ay_ff > by_ff;
      dx_c   = xneg_c ? (ax_ff - bx_ff) : (bx_ff - ax_ff);
      dy_c   = yneg_c ? (ay_ff - by_ff) : (by_ff - ay_ff);
   end

   assign div_dividend = (cmd.div_sel == dda_pkg::DivXByY) ? dx_c : dy_c;
   assign div_divisor  = (cmd.div_sel == dda_pkg::DivXByY) ? dy_c : dx_c;

   dda_div u_div (
      .clock     (clock),
      .reset     (reset),
      .go        (cmd.div_go),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // one DDA step from the current point
   always_comb begin
      dx_ext = $signed({{(AW-W){1'b0}}, dx_ff});
      dy_ext = $signed({{(AW-W){1'b0}}, dy_ff});
      qx_a   = qx_ff;
      qy_a   = qy_ff;
      rx_a   = rx_ff;
      ry_a   = ry_ff;
      if ((dx_ff != '0) && (dy_ff != '0)) begin
         qx_a = qx_ff + $signed({{(AW-W){1'b0}}, quo_xy_ff});
         qy_a = qy_ff + $signed({{(AW-W){1'b0}}, quo_yx_ff});
         rx_a = rx_ff + $signed({{(AW-W){1'b0}}, rem_xy_ff});
         ry_a = ry_ff + $signed({{(AW-W){1'b0}}, rem_yx_ff});
      end else if (dy_ff == '0) begin
         qx_a = qx_ff + AccOne;
      end else begin
         qy_a = qy_ff + AccOne;
      end
      step_x = (qx_a > 0) || (rx_a >= dy_ext);
      step_y = (qy_a > 0) || (ry_a >= dx_ext);
      x_in   = step_x ? (x_ff + (xneg_ff ? CoordDec : CoordInc)) : x_ff;
      y_in   = step_y ? (y_ff + (yneg_ff ? CoordDec : CoordInc)) : y_ff;
      qx_in  = step_x ? (qx_a - AccOne) : qx_a;
      rx_in  = step_x ? (rx_a - dy_ext) : rx_a;
      qy_in  = step_y ? (qy_a - AccOne) : qy_a;
      ry_in  = step_y ? (ry_a - dx_ext) : ry_a;
      ends   = ((x_ff == $signed({{(IW-W){1'b0}}, bx_ff})) &&
                (y_ff == $signed({{(IW-W){1'b0}}, by_ff}))) ||
               (x_ff == $signed({{(IW-W){1'b0}}, w_eff})) ||
               (y_ff == $signed({{(IW-W){1'b0}}, h_eff}));
      // current pixel is final if the line ends here, the length cap is reached or the next one falls below zero
      last_c = (first_ff && (dx_ff == '0) && (dy_ff == '0)) ||
               (!first_ff && ends) ||
               (cnt_ff == '1) ||
               x_in[IW-1] || y_in[IW-1];
   end

   always_comb begin
      sts          = '0;
      sts.both_nz  = (dx_c != '0) && (dy_c != '0);
      sts.div_done = div_done;
      sts.last     = last_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
      end
      if (cmd.setup) begin
         ax_ff <= clamp_coord(sx, w_eff);
         ay_ff <= clamp_coord(sy, h_eff);
         bx_ff <= clamp_coord(ex, w_eff);
         by_ff <= clamp_coord(ey, h_eff);
      end
      if (cmd.prep) begin
         dx_ff    <= dx_c;
         dy_ff    <= dy_c;
         xneg_ff  <= xneg_c;
         yneg_ff  <= yneg_c;
         x_ff     <= $signed({{(IW-W){1'b0}}, ax_ff});
         y_ff     <= $signed({{(IW-W){1'b0}}, ay_ff});
         qx_ff    <= '0;
         qy_ff    <= '0;
         rx_ff    <= '0;
         ry_ff    <= '0;
         cnt_ff   <= '0;
         first_ff <= 1'b1;
      end
      if (cmd.div_go) begin
         sel_ff <= cmd.div_sel;
      end
      if (div_done) begin
         if (sel_ff == dda_pkg::DivXByY) begin
            quo_xy_ff <= div_quo;
            rem_xy_ff <= div_rem;
         end else begin
            quo_yx_ff <= div_quo;
            rem_yx_ff <= div_rem;
         end
      end
      if (cmd.step) begin
         rsp_data_ff.pixel_x     <= x_ff[W-1:0];
         rsp_data_ff.pixel_y     <= y_ff[W-1:0];
         rsp_data_ff.pixel_color <= req_ff.pen_color;
         rsp_data_ff.last_pixel  <= last_c;
         x_ff     <= x_in;
         y_ff     <= y_in;
         qx_ff    <= qx_in;
         qy_ff    <= qy_in;
         rx_ff    <= rx_in;
         ry_ff    <= ry_in;
         cnt_ff   <= cnt_ff + CW'(1);
         first_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/dda_ctrl.sv =====
module dda_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  dda_pkg::dda_sts_type sts,
   output logic                 busy,
   output dda_pkg::dda_cmd_type cmd
);

   typedef enum logic [2:0] {
      IDLE,
      SETUP,
      CHECK,
      DIVX,
      DIVY,
      RUN
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = SETUP;
            end
         end
         SETUP: begin
            cmd.setup = 1'b1;
            state_in  = CHECK;
         end
         CHECK: begin
            cmd.prep = 1'b1;
            if (sts.both_nz) begin
               cmd.div_go  = 1'b1;
               cmd.div_sel = dda_pkg::DivXByY;
               state_in    = DIVX;
            end else begin
               state_in = RUN;
            end
         end
         DIVX: begin
            if (sts.div_done) begin
               cmd.div_go  = 1'b1;
               cmd.div_sel = dda_pkg::DivYByX;
               state_in    = DIVY;
            end
         end
         DIVY: begin
            if (sts.div_done) begin
               state_in = RUN;
            end
         end
         RUN: begin
            cmd.step = 1'b1;
            if (sts.last) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

// ===== hdl/dda_line_rasterizer.sv =====
// Channel   Ports                                 Transfer
// --------  ------------------------------------  -----------------------------------
// command   start, busy, req                      edge with start high and busy low
// pixel     rsp_valid, rsp_data                   every edge closing a rsp_valid cycle
// csr       csr_we, csr_index, csr_wdata          every edge with csr_we high
//
// Sequence: after a command transfer, the SETUP state orders and clamps the
// endpoints and the CHECK state derives the deltas. If both axes move, the shared
// 6-step divider runs twice (dx/dy, then dy/dx). Then one pixel per cycle, up to 64.
// Reset: synchronous, active high; canvas registers return to 63.
// Stalls: the pixel receiver cannot stall; busy drops with the last pixel.
module dda_line_rasterizer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  dda_pkg::dda_req_type       req,
   output logic                       rsp_valid,
   output dda_pkg::dda_rsp_type       rsp_data,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [dda_pkg::CoordW-1:0] csr_wdata
);

   logic [dda_pkg::CoordW-1:0] canvas_width_ff;
   logic [dda_pkg::CoordW-1:0] canvas_height_ff;
   dda_pkg::dda_cmd_type       cmd;
   dda_pkg::dda_sts_type       sts;

   // canvas registers; write them only while idle, a line reads them live
   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_width_ff  <= dda_pkg::CanvasReset;
         canvas_height_ff <= dda_pkg::CanvasReset;
      end else if (csr_we) begin
         if (csr_index == dda_pkg::CsrCanvasWidth) begin
            canvas_width_ff <= csr_wdata;
         end else begin
            canvas_height_ff <= csr_wdata;
         end
      end
   end

   // sequence setup, divisions and the pixel run
   dda_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .busy  (busy),
      .cmd   (cmd)
   );

   // hold the command, step the accumulators, drive each pixel transfer
   dda_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .canvas_width  (canvas_width_ff),
      .canvas_height (canvas_height_ff),
      .req           (req),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data)
   );

endmodule

// ===== hdl/dda_checker.sv =====
`include "dda_line_rasterizer_macros.svh"

module dda_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input dda_pkg::dda_rsp_type rsp_data
);

   `DDA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after transfer")
   `DDA_ASSERT_NEXT(a_run_gapless, rsp_valid && !rsp_data.last_pixel, rsp_valid, "gap in pixel run")
   `DDA_ASSERT_NEXT(a_color_held, rsp_valid && !rsp_data.last_pixel, rsp_data.pixel_color == $past(rsp_data.pixel_color), "color changed in run")
   `DDA_ASSERT_NOW(a_last_idle, rsp_valid && rsp_data.last_pixel, !busy, "busy after last pixel")
   `DDA_ASSERT_NOW(a_fall_last, $fell(busy), rsp_valid && rsp_data.last_pixel, "busy fell without last pixel")

endmodule

bind dda_line_rasterizer dda_checker u_dda_checker (.*);

// ===== tb/dda_line_rasterizer_tb.sv =====
module dda_line_rasterizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dda_pkg::*;

   // Clock, reset and block ports; every input holds a known value from time zero
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              start     = 1'b0;
   logic              busy;
   dda_req_type       req       = '0;
   logic              rsp_valid;
   dda_rsp_type       rsp_data;
   logic              csr_we    = 1'b0;
   logic              csr_index = CsrCanvasWidth;
   logic [CoordW-1:0] csr_wdata = '0;

   // Line commands waiting for the driver, and pixels the block still owes us
   dda_req_type line_cmd_q[$];
   dda_rsp_type pixel_expect_q[$];

   // Shadow copy of the canvas registers, as the block sees them
   int canvas_w_cfg = 63;
   int canvas_h_cfg = 63;

   int error_count = 0;

   // Sender pacing: bursts of commands separated by idle gaps
   int burst_left = 1;
   int gap_left   = 0;

   dda_rsp_type want_px;

   dda_line_rasterizer uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Trace one line command and append every pixel it should produce to the
   // expected-pixel store. Uses the canvas size in force when the command transfers.
   function automatic void trace_line(input dda_req_type cmd);
      int w, h, ax, ay, bx, by, t, dx, dy, x, y;
      int qx, qy, rx, ry, n;
      dda_rsp_type pend;
      w  = (canvas_w_cfg > int'(MaxCanvas)) ? int'(MaxCanvas) : canvas_w_cfg;
      h  = (canvas_h_cfg > int'(MaxCanvas)) ? int'(MaxCanvas) : canvas_h_cfg;
      ax = $signed(cmd.start_x);
      ay = $signed(cmd.start_y);
      bx = $signed(cmd.end_x);
      by = $signed(cmd.end_y);
      qx = 0;
      qy = 0;
      rx = 0;
      ry = 0;
      // Swap both axes together when the start lies beyond the finish in either one
      if (ax > bx || ay > by) begin
         t = ax; ax = bx; bx = t;
         t = ay; ay = by; by = t;
      end
      // Clamp every coordinate onto the canvas
      ax = (ax > w) ? w : ((ax < 0) ? 0 : ax);
      bx = (bx > w) ? w : ((bx < 0) ? 0 : bx);
      ay = (ay > h) ? h : ((ay < 0) ? 0 : ay);
      by = (by > h) ? h : ((by < 0) ? 0 : by);
      dx = (bx > ax) ? bx - ax : ax - bx;
      dy = (by > ay) ? by - ay : ay - by;
      x  = ax;
      y  = ay;
      // Hold each pixel back one step so the final one can carry the last flag
      pend.pixel_x     = CoordW'(x);
      pend.pixel_y     = CoordW'(y);
      pend.pixel_color = cmd.pen_color;
      pend.last_pixel  = 1'b0;
      n = 1;
      if (dx != 0 || dy != 0) begin
         while (n < 64) begin
            // Advance the quotient and remainder accumulators
            if (dx != 0 && dy != 0) begin
               qx += dx / dy;
               qy += dy / dx;
               ry += dy % dx;
               rx += dx % dy;
            end else if (dy == 0) begin
               qx += 1;
            end else begin
               qy += 1;
            end
            if (qx >= 1 || rx >= dy) begin
               x  += (ax > bx) ? -1 : 1;
               qx -= 1;
               rx -= dy;
            end
            if (qy >= 1 || ry >= dx) begin
               y  += (ay > by) ? -1 : 1;
               qy -= 1;
               ry -= dx;
            end
            // Drop a step that leaves the canvas below zero; the line ends before it
            if (x < 0 || y < 0)
               break;
            pixel_expect_q.push_back(pend);
            pend.pixel_x = CoordW'(x);
            pend.pixel_y = CoordW'(y);
            n++;
            // Stop on the finish or on the far canvas edge
            if ((x == bx && y == by) || x == w || y == h)
               break;
         end
      end
      pend.last_pixel = 1'b1;
      pixel_expect_q.push_back(pend);
   endfunction

   // Driver: present queued commands in bursts, hold start until the transfer
   always @(posedge clock) begin
      if (reset) begin
         start      <= 1'b0;
         burst_left = 1;
         gap_left   = 0;
      end else begin
         // A transfer happens on this edge: predict its pixels now
         if (start && !busy)
            trace_line(req);
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (line_cmd_q.size() > 0) begin
               req   <= line_cmd_q.pop_front();
               start <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 12);
                  // Leave some bursts back to back, separate the rest by a random gap
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 25);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed cycle is one pixel transfer; match it against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pixel_expect_q.size() == 0) begin
            $display("%0t: unexpected pixel x=%0d y=%0d color=%0d last=%0d", $time,
                     rsp_data.pixel_x, rsp_data.pixel_y, rsp_data.pixel_color,
                     rsp_data.last_pixel);
            error_count++;
         end else begin
            want_px = pixel_expect_q.pop_front();
            if (rsp_data !== want_px) begin
               $display("%0t: pixel mismatch expected x=%0d y=%0d color=%0d last=%0d",
                        $time, want_px.pixel_x, want_px.pixel_y, want_px.pixel_color,
                        want_px.last_pixel);
               $display("%0t:                  actual x=%0d y=%0d color=%0d last=%0d",
                        $time, rsp_data.pixel_x, rsp_data.pixel_y, rsp_data.pixel_color,
                        rsp_data.last_pixel);
               error_count++;
            end
         end
      end
   end

   task automatic queue_line(input int sx, sy, ex, ey, col);
      dda_req_type cmd;
      cmd.start_x   = InW'(sx);
      cmd.start_y   = InW'(sy);
      cmd.end_x     = InW'(ex);
      cmd.end_y     = InW'(ey);
      cmd.pen_color = ColorW'(col);
      line_cmd_q.push_back(cmd);
   endtask

   // Hold until every command has transferred and every pixel has come back;
   // look between rising edges so the driver's updates have settled
   task automatic wait_idle();
      do
         @(negedge clock);
      while (line_cmd_q.size() != 0 || start || busy || pixel_expect_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_canvas(input int w, h);
      @(posedge clock);
      csr_we       <= 1'b1;
      csr_index    <= CsrCanvasWidth;
      csr_wdata    <= CoordW'(w);
      canvas_w_cfg = w;
      @(posedge clock);
      csr_index    <= CsrCanvasHeight;
      csr_wdata    <= CoordW'(h);
      canvas_h_cfg = h;
      @(posedge clock);
      csr_we       <= 1'b0;
   endtask

   // Mostly coordinates near the canvas so lines reach the interesting stepping,
   // the rest anywhere in the 8-bit range
   function automatic int pick_coord(input int lim);
      if ($urandom_range(0, 4) == 0)
         return int'($urandom_range(0, 255));
      return int'($urandom_range(0, lim + 16)) - 8;
   endfunction

   task automatic run_phase(input int w, h, count);
      int sx, sy, ex, ey;
      write_canvas(w, h);
      repeat (count) begin
         sx = pick_coord(w);
         sy = pick_coord(h);
         ex = pick_coord(w);
         ey = pick_coord(h);
         // Force a zero-length line now and then
         if ($urandom_range(0, 15) == 0) begin
            ex = sx;
            ey = sy;
         end
         queue_line(sx, sy, ex, ey, $urandom_range(0, 255));
      end
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed lines on the reset canvas size
      queue_line(0, 0, 0, 0, 8'h00);           // zero length at the origin
      queue_line(63, 63, 63, 63, 8'hFF);       // zero length at the far corner
      queue_line(-128, -128, 127, 127, 8'hA5); // fully clamped diagonal, hits the length cap
      queue_line(127, 127, -128, -128, 8'h5A); // same, endpoints swapped
      queue_line(0, 0, 63, 0, 8'h01);          // full horizontal
      queue_line(0, 0, 0, 63, 8'h80);          // full vertical
      queue_line(10, 5, 40, 5, 8'h3C);
      queue_line(5, 40, 5, 10, 8'hC3);         // vertical, swapped
      queue_line(0, 0, 50, 20, 8'h11);         // shallow slope
      queue_line(3, 1, 9, 40, 8'h22);          // steep slope
      queue_line(30, 2, 10, 20, 8'h33);        // swap leaves y falling, runs below zero
      queue_line(10, 0, 0, 30, 8'h44);
      queue_line(5, 5, -3, 20, 8'h55);         // clamped start after swap
      queue_line(127, -128, -128, 127, 8'h66);
      queue_line(-128, 127, 127, -128, 8'h77);
      queue_line(62, 0, 63, 1, 8'h88);         // reaches the edge at once
      queue_line(1, 2, 2, 1, 8'h99);
      queue_line(20, 20, 27, 23, 8'hAA);       // finish missed, runs on to an edge
      queue_line(-1, -1, -1, -1, 8'hFE);       // zero length below the canvas
      wait_idle();

      // Random lines across canvas sizes, the extremes among them
      run_phase(1, 1, 59);
      run_phase(63, 1, 59);
      run_phase(1, 63, 59);
      run_phase($urandom_range(2, 62), $urandom_range(2, 62), 59);
      run_phase($urandom_range(2, 62), $urandom_range(2, 62), 59);
      run_phase(63, 63, 59);

      repeat (40) @(posedge clock);
      if (error_count == 0 && pixel_expect_q.size() == 0) begin
         $display("dda_line_rasterizer_tb passed");
      end else begin
         $display("dda_line_rasterizer_tb failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #1000000;
      $display("dda_line_rasterizer_tb failed");
      $finish;
   end

endmodule
